[sv/dba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and constants for the dual bitmap allocator.
// ----------------------------------------------------------------------------
package dba_pkg;

    // Bitmap storage word: one bit per entry, WORD_W entries per memory row.
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int DISK_W   = 7;

    localparam logic [DISK_W-1:0] DEV_BLOCKS_RST = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC_INODE = 2'd0,
        KIND_FREE_INODE  = 2'd1,
        KIND_ALLOC_BLOCK = 2'd2,
        KIND_FREE_BLOCK  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [INDEX_W-1:0]  index;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [INDEX_W-1:0]  granted;
    } t_out_item;

    // Request from the top level into one pool.
    typedef struct packed {
        logic                free;
        logic [INDEX_W-1:0]  index;
    } t_pool_req;

    typedef enum logic [1:0] {
        PS_IDLE = 2'd0,
        PS_EVAL = 2'd1,
        PS_DONE = 2'd2
    } t_pool_state;

endpackage

[sv/dba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dba_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_pool
// One allocation pool: bitmap in RAM, per-row valid bits, used count,
// first-fit word scan and read-modify-write of one row per request.
// ----------------------------------------------------------------------------
module dba_pool #(
    parameter int COUNT = 32,
    localparam int CW = $clog2(COUNT + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dba_pkg::t_pool_req  i_req,
    input  logic [CW-1:0]       i_limit,
    output logic                o_done,
    output dba_pkg::t_out_item  o_rsp,
    input  logic                i_take
);

    localparam int W     = dba_pkg::WORD_W;
    localparam int BW    = dba_pkg::BIT_W;
    localparam int WORDS = (COUNT + W - 1) / W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int REM   = COUNT - (WORDS - 1) * W;
    // Bits past the last entry in the last row count as used during a scan.
    localparam logic [W-1:0] PAD = ~({W{1'b1}} >> (W - REM));
    localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

    dba_pkg::t_pool_state r_state, n_state;
    logic [AW-1:0]        r_addr, n_addr;
    logic                 r_free, n_free;
    logic [BW-1:0]        r_bit, n_bit;
    logic [CW-1:0]        r_count, n_count;
    logic [WORDS-1:0]     r_rowv;
    dba_pkg::t_out_item   r_rsp, n_rsp;

    logic                 ram_we, ram_re;
    logic [W-1:0]         ram_wdata, ram_q;
    logic [W-1:0]         word, search;
    logic                 found;
    logic [BW-1:0]        pos;
    logic [AW+BW-1:0]     slot;
    logic                 in_range;
    logic [AW-1:0]        req_word;

    dba_ram #(.WIDTH(W), .DEPTH(WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (n_addr),
        .o_rdata (ram_q)
    );

    // A row never written reads as all free.
    assign word   = r_rowv[r_addr] ? ram_q : '0;
    assign search = word | ((r_addr == LAST) ? PAD : '0);
    assign slot   = {r_addr, pos};

    assign in_range = (32'(i_req.index) < COUNT);
    assign req_word = AW'(i_req.index >> BW);

    // Lowest clear bit of the row.
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (!search[i]) begin
                found = 1'b1;
                pos   = BW'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_free    = r_free;
        n_bit     = r_bit;
        n_count   = r_count;
        n_rsp     = r_rsp;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = word;
        unique case (r_state)
            dba_pkg::PS_IDLE: begin
                if (i_start) begin
                    n_free        = i_req.free;
                    n_rsp.status  = dba_pkg::ST_OK;
                    n_rsp.granted = '0;
                    if (i_req.free) begin
                        if (!in_range) begin
                            n_rsp.status = dba_pkg::ST_BAD_FREE;
                            n_state      = dba_pkg::PS_DONE;
                        end else begin
                            n_addr  = req_word;
                            n_bit   = i_req.index[BW-1:0];
                            ram_re  = 1'b1;
                            n_state = dba_pkg::PS_EVAL;
                        end
                    end else if (r_count >= i_limit) begin
                        n_rsp.status = dba_pkg::ST_FULL;
                        n_state      = dba_pkg::PS_DONE;
                    end else begin
                        n_addr  = '0;
                        ram_re  = 1'b1;
                        n_state = dba_pkg::PS_EVAL;
                    end
                end
            end
            dba_pkg::PS_EVAL: begin
                if (r_free) begin
                    if (word[r_bit]) begin
                        ram_we    = 1'b1;
                        ram_wdata = word & ~(W'(1) << r_bit);
                        n_count   = r_count - CW'(1);
                    end else begin
                        n_rsp.status = dba_pkg::ST_BAD_FREE;
                    end
                    n_state = dba_pkg::PS_DONE;
                end else if (found) begin
                    ram_we        = 1'b1;
                    ram_wdata     = word | (W'(1) << pos);
                    n_count       = r_count + CW'(1);
                    n_rsp.granted = slot[dba_pkg::INDEX_W-1:0];
                    n_state       = dba_pkg::PS_DONE;
                end else if (r_addr == LAST) begin
                    n_rsp.status = dba_pkg::ST_FULL;
                    n_state      = dba_pkg::PS_DONE;
                end else begin
                    // Row full: move on to the next one.
                    n_addr = r_addr + AW'(1);
                    ram_re = 1'b1;
                end
            end
            dba_pkg::PS_DONE: begin
                if (i_take) begin
                    n_state = dba_pkg::PS_IDLE;
                end
            end
            default: begin
                n_state = dba_pkg::PS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dba_pkg::PS_IDLE;
            r_count <= '0;
            r_rowv  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (ram_we) begin
                r_rowv[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_free <= n_free;
        r_bit  <= n_bit;
        r_rsp  <= n_rsp;
    end

    assign o_done = (r_state == dba_pkg::PS_DONE);
    assign o_rsp  = r_rsp;

endmodule

[sv/dual_bitmap_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_bitmap_allocator_core
// First-fit allocator for an inode pool and a data block pool, each kept as
// a used bitmap in RAM plus a used count.
// ----------------------------------------------------------------------------
//  Channel | Signals                                 | Dir | Moves
//  --------+-----------------------------------------+-----+-------------------
//  in      | i_in_valid, o_in_ready, i_in_item       | in  | one request
//  out     | o_out_valid, i_out_ready, o_out_item    | out | one result
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data    | in  | device size write
//
//  A request reads one bitmap row (32 entries a row) per pass through
//  PS_EVAL, waits in PS_DONE until the result register takes it, and only
//  then is the next request accepted; the scan issues one RAM read per
//  cycle, so an allocation walks up to ceil(COUNT/32) rows.
//  Frees and early refusals read one row or none.
//  Reset: synchronous, active low; clears control, counts and the per-row
//  valid bits, so the bitmaps read as all free with no clearing pass.
//  Stalls: the result register parts the sides; a result waiting on
//  i_out_ready holds the next request in its pool until the register frees.
// ----------------------------------------------------------------------------
module dual_bitmap_allocator_core #(
    parameter int INODE_COUNT = 32,
    parameter int BLOCK_COUNT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dba_pkg::t_in_item              i_in_item,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dba_pkg::t_out_item             o_out_item,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dba_pkg::DISK_W-1:0]     i_cfg_data
);

    localparam int ICW = $clog2(INODE_COUNT + 1);
    localparam int BCW = $clog2(BLOCK_COUNT + 1);

    logic                          r_busy;
    logic                          r_sel_block;
    logic [dba_pkg::DISK_W-1:0]    r_disk;
    logic                          r_out_valid;
    dba_pkg::t_out_item            r_out_item;

    logic                          in_acc;
    logic                          is_block;
    logic                          out_free;
    logic                          take;
    dba_pkg::t_pool_req            req;
    logic [BCW-1:0]                block_limit;
    logic                          inode_done, block_done;
    dba_pkg::t_out_item            inode_rsp, block_rsp;
    dba_pkg::t_out_item            sel_rsp;
    logic                          sel_done;

    // One request in flight at a time; the pools hold it until taken.
    assign o_in_ready  = !r_busy;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign is_block  = (i_in_item.kind == dba_pkg::KIND_ALLOC_BLOCK) ||
                       (i_in_item.kind == dba_pkg::KIND_FREE_BLOCK);
    assign req.free  = (i_in_item.kind == dba_pkg::KIND_FREE_INODE) ||
                       (i_in_item.kind == dba_pkg::KIND_FREE_BLOCK);
    assign req.index = i_in_item.index;

    // Counting against min(r_disk, BLOCK_COUNT) matches the scan running
    // out of free blocks when the device size exceeds the pool.
    always_comb begin
        if (32'(r_disk) < BLOCK_COUNT) begin
            block_limit = BCW'(r_disk);
        end else begin
            block_limit = BCW'(BLOCK_COUNT);
        end
    end

    dba_pool #(.COUNT(INODE_COUNT)) u_inode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && !is_block),
        .i_req   (req),
        .i_limit (ICW'(INODE_COUNT)),
        .o_done  (inode_done),
        .o_rsp   (inode_rsp),
        .i_take  (take && !r_sel_block)
    );

    dba_pool #(.COUNT(BLOCK_COUNT)) u_block (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && is_block),
        .i_req   (req),
        .i_limit (block_limit),
        .o_done  (block_done),
        .o_rsp   (block_rsp),
        .i_take  (take && r_sel_block)
    );

    assign sel_done = r_sel_block ? block_done : inode_done;
    assign sel_rsp  = r_sel_block ? block_rsp  : inode_rsp;
    assign out_free = !r_out_valid || i_out_ready;
    assign take     = r_busy && sel_done && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_disk      <= dba_pkg::DEV_BLOCKS_RST;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_disk <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sel_block <= is_block;
        end
        if (take) begin
            r_out_item <= sel_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[sv/dba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_checker
// Port-level checks for the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module dba_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input dba_pkg::t_in_item          i_in_item,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input dba_pkg::t_out_item         o_out_item,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [dba_pkg::DISK_W-1:0] i_cfg_data
);

    // Stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A request is served alone: no second transaction right behind it.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Refusals never carry a grant.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != dba_pkg::ST_OK)
            |-> o_out_item.granted == '0)
        else $error("nonzero grant on failed request");

    // A new result only comes out of a request in flight.
    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without a pending request");

endmodule

bind dual_bitmap_allocator_core dba_checker u_dba_checker (.*);
